// ===== hw/rtl/bgbs_pkg.sv =====
// ----------------------------------------------------------------------------
// bgbs_pkg
// Shared widths, register indexes, phase codes, reset values and payload types
// for the battery gated boost sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bgbs_pkg;

    // Field widths
    localparam int unsigned ELAPSED_W  = 8;
    localparam int unsigned ADC_W      = 10;
    localparam int unsigned CH_W       = 2;
    localparam int unsigned MV_W       = 15;
    localparam int unsigned TIMER_W    = 16;
    localparam int unsigned GAIN_W     = 22;
    localparam int unsigned OFFSET_W   = 8;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 22;

    // Scaled sum and product widths
    localparam int unsigned SUM_W  = ADC_W + 1;
    localparam int unsigned PROD_W = SUM_W + GAIN_W;
    localparam int unsigned FRAC_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUALIFY_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_STARTUP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_OFFSET   = 3'd5;

    // Boost converter phase codes
    localparam logic [PHASE_W-1:0] PHASE_OFF     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_STARTUP = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_ACTIVE  = 2'd2;

    // Saturation limit of the scaled voltage
    localparam logic [MV_W-1:0] MV_MAX = 15'h7FFF;

    // Register reset values
    localparam logic [MV_W-1:0]     RST_LOW_THRESHOLD  = 15'd11800;
    localparam logic [MV_W-1:0]     RST_HIGH_THRESHOLD = 15'd12600;
    localparam logic [TIMER_W-1:0]  RST_QUALIFY_TIME   = 16'd30000;
    localparam logic [TIMER_W-1:0]  RST_BOOST_STARTUP  = 16'd1000;
    localparam logic [GAIN_W-1:0]   RST_SCALE_GAIN     = 22'd1868431;
    localparam logic [OFFSET_W-1:0] RST_SCALE_OFFSET   = 8'd11;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 adc_valid;
        logic [ADC_W-1:0]     adc_sample;
        logic                 request_write;
        logic [CH_W-1:0]      request_channels;
    } t_in_item;

    typedef struct packed {
        logic [MV_W-1:0]    voltage_mv;
        logic               battery_ok;
        logic [PHASE_W-1:0] boost_phase;
        logic               boost_pwm_on;
        logic [CH_W-1:0]    channel_drive;
        logic [CH_W-1:0]    channels_held;
    } t_out_item;

    typedef struct packed {
        logic [MV_W-1:0]     low_threshold_mv;
        logic [MV_W-1:0]     high_threshold_mv;
        logic [TIMER_W-1:0]  qualify_time_ms;
        logic [TIMER_W-1:0]  boost_startup_ms;
        logic [GAIN_W-1:0]   scale_gain;
        logic [OFFSET_W-1:0] scale_offset;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/bgbs_if.sv =====
// ----------------------------------------------------------------------------
// bgbs_if
// Valid/ready channels of the sequencer: input items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgbs_in_if;
    import bgbs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bgbs_out_if;
    import bgbs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bgbs_cfg_if;
    import bgbs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bgbs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bgbs_cfg_regs
// Configuration register file. Takes one write per cycle; an index beyond
// the register list is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbs_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    bgbs_cfg_if.sink            i_cfg,
    output bgbs_pkg::t_cfg      o_cfg
);
    import bgbs_pkg::*;

    t_cfg r_cfg;
    logic cfg_xfer;

    // Always able to take a write
    assign i_cfg.ready = 1'b1;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;

    // Write the addressed register, masked to its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold_mv  <= RST_LOW_THRESHOLD;
            r_cfg.high_threshold_mv <= RST_HIGH_THRESHOLD;
            r_cfg.qualify_time_ms   <= RST_QUALIFY_TIME;
            r_cfg.boost_startup_ms  <= RST_BOOST_STARTUP;
            r_cfg.scale_gain        <= RST_SCALE_GAIN;
            r_cfg.scale_offset      <= RST_SCALE_OFFSET;
        end else if (cfg_xfer) begin
            case (i_cfg.index)
                REG_LOW_THRESHOLD:  r_cfg.low_threshold_mv  <= i_cfg.wdata[MV_W-1:0];
                REG_HIGH_THRESHOLD: r_cfg.high_threshold_mv <= i_cfg.wdata[MV_W-1:0];
                REG_QUALIFY_TIME:   r_cfg.qualify_time_ms   <= i_cfg.wdata[TIMER_W-1:0];
                REG_BOOST_STARTUP:  r_cfg.boost_startup_ms  <= i_cfg.wdata[TIMER_W-1:0];
                REG_SCALE_GAIN:     r_cfg.scale_gain        <= i_cfg.wdata[GAIN_W-1:0];
                REG_SCALE_OFFSET:   r_cfg.scale_offset      <= i_cfg.wdata[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/bgbs_scale.sv =====
// ----------------------------------------------------------------------------
// bgbs_scale
// ADC to millivolt conversion: (sample + offset) * gain with the gain in 6.16
// fixed point, saturated to the 15-bit voltage range.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbs_scale (
    input  wire logic [bgbs_pkg::ADC_W-1:0]    i_sample,
    input  wire logic [bgbs_pkg::OFFSET_W-1:0] i_offset,
    input  wire logic [bgbs_pkg::GAIN_W-1:0]   i_gain,
    output logic      [bgbs_pkg::MV_W-1:0]     o_mv
);
    import bgbs_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic              sat;

    // Offset the reading and multiply by the gain (11 x 22 bits)
    assign sum  = {1'b0, i_sample} + {{(SUM_W-OFFSET_W){1'b0}}, i_offset};
    assign prod = {{GAIN_W{1'b0}}, sum} * {{SUM_W{1'b0}}, i_gain};

    // Drop the fraction and clamp anything above the 15-bit range
    assign sat  = |prod[PROD_W-1:FRAC_W+MV_W];
    assign o_mv = sat ? MV_MAX : prod[FRAC_W+MV_W-1:FRAC_W];

endmodule

`default_nettype wire

// ===== hw/rtl/bgbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgbs_ctrl
// Control state of the sequencer: countdown timers, battery monitor with
// hysteresis, channel request store and boost phase. Computes the next
// state and the result of one item and commits it when the item advances.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbs_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_advance,
    input  wire bgbs_pkg::t_in_item     i_item,
    input  wire logic [bgbs_pkg::MV_W-1:0] i_mv,
    input  wire bgbs_pkg::t_cfg         i_cfg,
    output bgbs_pkg::t_out_item         o_result
);
    import bgbs_pkg::*;

    logic               r_good;
    logic [TIMER_W-1:0] r_bat_tmr;
    logic [PHASE_W-1:0] r_phase;
    logic [TIMER_W-1:0] r_boost_tmr;
    logic [CH_W-1:0]    r_chan;
    logic [MV_W-1:0]    r_volt;

    logic               n_good;
    logic [TIMER_W-1:0] n_bat_tmr;
    logic [PHASE_W-1:0] n_phase;
    logic [TIMER_W-1:0] n_boost_tmr;
    logic [CH_W-1:0]    n_chan;
    logic [MV_W-1:0]    n_volt;

    logic [TIMER_W-1:0] elapsed;
    logic [TIMER_W-1:0] bat_cnt;
    logic [TIMER_W-1:0] boost_cnt;
    logic [CH_W-1:0]    chan_req;
    logic [CH_W-1:0]    held;

    // Count both timers down, stopping at zero
    assign elapsed   = {{(TIMER_W-ELAPSED_W){1'b0}}, i_item.elapsed_ms};
    assign bat_cnt   = (r_bat_tmr > elapsed) ? (r_bat_tmr - elapsed) : '0;
    assign boost_cnt = (r_boost_tmr > elapsed) ? (r_boost_tmr - elapsed) : '0;

    // Battery monitor: reload the timer while the crossing is absent
    always_comb begin
        n_good    = r_good;
        n_bat_tmr = bat_cnt;
        n_volt    = r_volt;
        if (i_item.adc_valid) begin
            n_volt = i_mv;
            if (!r_good) begin
                if (i_mv < i_cfg.high_threshold_mv) begin
                    n_bat_tmr = i_cfg.qualify_time_ms;
                end else if (bat_cnt == '0) begin
                    n_good = 1'b1;
                end
            end else begin
                if (i_mv > i_cfg.low_threshold_mv) begin
                    n_bat_tmr = i_cfg.qualify_time_ms;
                end else if (bat_cnt == '0) begin
                    n_good = 1'b0;
                end
            end
        end
    end

    // Store a new request and drop it while the battery is empty
    assign chan_req = i_item.request_write ? i_item.request_channels : r_chan;
    assign held     = n_good ? chan_req : '0;
    assign n_chan   = held;

    // Boost phase: off, startup for the programmed time, then active
    always_comb begin
        n_phase     = r_phase;
        n_boost_tmr = boost_cnt;
        if (held != '0) begin
            case (r_phase)
                PHASE_OFF: begin
                    n_phase     = PHASE_STARTUP;
                    n_boost_tmr = i_cfg.boost_startup_ms;
                end
                PHASE_STARTUP: begin
                    if (boost_cnt == '0) begin
                        n_phase = PHASE_ACTIVE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end else begin
            n_phase = PHASE_OFF;
        end
    end

    // Commit the state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good      <= 1'b0;
            r_bat_tmr   <= '0;
            r_phase     <= PHASE_OFF;
            r_boost_tmr <= '0;
            r_chan      <= '0;
            r_volt      <= '0;
        end else if (i_advance) begin
            r_good      <= n_good;
            r_bat_tmr   <= n_bat_tmr;
            r_phase     <= n_phase;
            r_boost_tmr <= n_boost_tmr;
            r_chan      <= n_chan;
            r_volt      <= n_volt;
        end
    end

    // Build the result from the post-item state
    always_comb begin
        o_result.voltage_mv    = n_volt;
        o_result.battery_ok    = n_good;
        o_result.boost_phase   = n_phase;
        o_result.boost_pwm_on  = (n_phase != PHASE_OFF);
        o_result.channel_drive = (n_phase == PHASE_ACTIVE) ? held : '0;
        o_result.channels_held = held;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/battery_gated_boost_sequencer.sv =====
// ----------------------------------------------------------------------------
// battery_gated_boost_sequencer
// One control pass per item: ADC scaling, battery hysteresis monitor,
// channel request gating and boost converter phase sequencing.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the output stalls it, and
// returns exactly one result per item: the item is captured in
// an input register, the full control pass (one 11 x 22 bit multiply,
// timer countdown, threshold compares and phase update) runs in a single
// combinational stage, and the result lands in an output register. The
// control state is updated in the same cycle the result is registered, so
// the next item sees it right away. Input ready drops only while a result
// waits in the output register and another item waits in the input
// register. Configuration writes are taken every cycle and must be made
// while no item is in flight.
`default_nettype none

module battery_gated_boost_sequencer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bgbs_in_if.sink     i_in,
    bgbs_out_if.source  o_out,
    bgbs_cfg_if.sink    i_cfg
);
    import bgbs_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    t_cfg            cfg;
    t_out_item       result;
    logic [MV_W-1:0] mv;
    logic            advance;

    // Configuration registers
    bgbs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Move the held item on when the result register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // Scale the ADC reading
    bgbs_scale u_scale (
        .i_sample (r_in.adc_sample),
        .i_offset (cfg.scale_offset),
        .i_gain   (cfg.scale_gain),
        .o_mv     (mv)
    );

    // Control state and next result
    bgbs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_mv      (mv),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Result register: load on advance, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Channels are driven only while the converter is active
    a_drive_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.channel_drive != '0))
            |-> (o_out.data.boost_phase == PHASE_ACTIVE))
        else $error("channel drive outside active phase");

    // A held request implies a good battery
    a_held_needs_battery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.channels_held != '0)) |-> o_out.data.battery_ok)
        else $error("channel request held with empty battery");

    // Input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output backpressure");

    // A result follows every advance
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out.valid)
        else $error("advanced item produced no result");

endmodule

`default_nettype wire
